FILE: src/search_hash_table_probe_store_core_assert.svh
// assertion macros shared by the probe store rtl
`ifndef SEARCH_HASH_TABLE_PROBE_STORE_CORE_ASSERT_SVH
`define SEARCH_HASH_TABLE_PROBE_STORE_CORE_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define SHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define SHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sht_pkg.sv
// ----------------------------------------------------------------------------
// sht_pkg
// types, codes and widths of the hash table probe store
// ----------------------------------------------------------------------------
package sht_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 7;
    localparam int SCORE_W = 16;
    localparam int MOVE_W  = 32;
    localparam int AGE_W   = 16;
    localparam int MODE_W  = 2;
    localparam int FLAGS_W = 2;

    // key bits folded into the remainder per cycle when the depth is no power of two
    localparam int MOD_DIGIT_W = 4;

    localparam logic [MODE_W-1:0] MODE_PROBE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STORE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [FLAGS_W-1:0] FLAGS_UPPER = 2'd1;
    localparam logic [FLAGS_W-1:0] FLAGS_LOWER = 2'd2;
    localparam logic [FLAGS_W-1:0] FLAGS_EXACT = 2'd3;

    localparam logic [DEPTH_W-1:0] CUT_MIN_DEPTH = 7'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [DEPTH_W-1:0] depth;
        logic [AGE_W-1:0]   age;
        logic [FLAGS_W-1:0] flags;
    } t_meta;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]  move;
        logic               move_valid;
    } t_entry;

endpackage

FILE: src/search_hash_table_probe_store_core.sv
// path: a probe or store word goes from acceptance to the read state and then into the
//   result register when TABLE_DEPTH is a power of two, otherwise through key reduction
//   first, 4 key bits a cycle; a new word is taken only in the idle state, after the
//   synchronous read of the entry and, for a store, its write-back in the read state
// clear: the sweep empties every entry, one entry a cycle, then gives its zero result word
// reset: synchronous, active low; afterwards the table is swept with the input stalled,
//   search age is zero
// ----------------------------------------------------------------------------
// search_hash_table_probe_store_core
// direct-mapped transposition table with depth and age replacement
// ----------------------------------------------------------------------------
`include "search_hash_table_probe_store_core_assert.svh"

module search_hash_table_probe_store_core
    import sht_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_wr_en,
    input  logic [AGE_W-1:0]          i_cfg_wr_data,
    // request channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic [KEY_W-1:0]          i_key,
    input  logic [DEPTH_W-1:0]        i_depth,
    input  logic signed [SCORE_W-1:0] i_alpha,
    input  logic signed [SCORE_W-1:0] i_beta,
    input  logic signed [SCORE_W-1:0] i_score_in,
    input  logic [FLAGS_W-1:0]        i_bound_flags,
    input  logic [MOVE_W-1:0]         i_move_in,
    input  logic                      i_move_in_valid,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_cutoff,
    output logic signed [SCORE_W-1:0] o_score_out,
    output logic                      o_move_found,
    output logic [MOVE_W-1:0]         o_move_out,
    output logic                      o_key_hit
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam bit IS_POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [IDX_W:0] DEPTH_EXT = (IDX_W + 1)'(TABLE_DEPTH);
    localparam int MOD_STEPS = KEY_W / MOD_DIGIT_W;
    localparam int STEP_W = $clog2(MOD_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MOD_STEPS - 1);

    // control state
    t_state r_state, n_state;
    logic [IDX_W-1:0]  r_cnt, n_cnt;       // sweep address
    logic [AGE_W-1:0]  r_age, n_age;       // search age register
    logic              r_out_valid, n_out_valid;

    // key reduction and entry address
    logic [STEP_W-1:0] r_mod_cnt, n_mod_cnt;
    logic [IDX_W-1:0]  r_rem, n_rem;
    logic [IDX_W-1:0]  r_idx, n_idx;

    // request word held while it is worked on
    logic [MODE_W-1:0]         r_mode;
    logic [KEY_W-1:0]          r_key;
    logic [DEPTH_W-1:0]        r_depth;
    logic signed [SCORE_W-1:0] r_alpha;
    logic signed [SCORE_W-1:0] r_beta;
    logic signed [SCORE_W-1:0] r_score;
    logic [FLAGS_W-1:0]        r_flags;
    logic [MOVE_W-1:0]         r_move;
    logic                      r_move_valid;

    // result register
    logic                      r_cutoff, n_cutoff;
    logic signed [SCORE_W-1:0] r_score_out, n_score_out;
    logic                      r_move_found, n_move_found;
    logic [MOVE_W-1:0]         r_move_out, n_move_out;
    logic                      r_key_hit, n_key_hit;

    // table memories: meta is swept clear, entry data is only used behind a valid meta
    t_meta  meta_mem [TABLE_DEPTH];
    t_entry data_mem [TABLE_DEPTH];
    t_meta  r_meta_rd;
    t_entry r_data_rd;

    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_meta_we;
    logic [IDX_W-1:0] w_meta_waddr;
    t_meta            w_meta_wdata;
    logic             w_data_we;
    t_entry           w_data_wdata;

    logic                      w_in_acc;
    logic                      w_out_free;
    logic [MOD_DIGIT_W-1:0]    w_digit;
    logic [STEP_W-1:0]         w_digit_sel;
    logic [IDX_W-1:0]          w_rem_step;
    logic                      w_hit;
    logic                      w_depth_ok;
    logic                      w_cut;
    logic signed [SCORE_W-1:0] w_cut_val;
    logic                      w_replace;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_cutoff     = r_cutoff;
    assign o_score_out  = r_score_out;
    assign o_move_found = r_move_found;
    assign o_move_out   = r_move_out;
    assign o_key_hit    = r_key_hit;

    // one radix-16 digit of key mod TABLE_DEPTH, most significant digit first
    assign w_digit_sel = LAST_STEP - r_mod_cnt;
    assign w_digit     = r_key[int'(w_digit_sel) * MOD_DIGIT_W +: MOD_DIGIT_W];

    always_comb begin
        logic [IDX_W:0] v_t;
        logic [IDX_W-1:0] v_rem;
        v_rem = r_rem;
        for (int b = MOD_DIGIT_W - 1; b >= 0; b--) begin
            // remainder stays below the depth, so one subtract is enough per bit
            v_t = {v_rem, w_digit[b]};
            if (v_t >= DEPTH_EXT) begin
                v_t = v_t - DEPTH_EXT;
            end
            v_rem = v_t[IDX_W-1:0];
        end
        w_rem_step = v_rem;
    end

    // probe evaluation on the entry held in the read registers
    assign w_hit      = (r_mode == MODE_PROBE) && r_meta_rd.valid && (r_data_rd.key == r_key);
    assign w_depth_ok = (r_depth > CUT_MIN_DEPTH) && (r_depth <= r_meta_rd.depth);

    always_comb begin
        w_cut     = 1'b0;
        w_cut_val = '0;
        if (w_depth_ok) begin
            case (r_meta_rd.flags)
                FLAGS_EXACT: begin
                    w_cut     = 1'b1;
                    w_cut_val = $signed(r_data_rd.score);
                end
                FLAGS_UPPER: begin
                    if ($signed(r_data_rd.score) <= r_alpha) begin
                        w_cut     = 1'b1;
                        w_cut_val = r_alpha;
                    end
                end
                FLAGS_LOWER: begin
                    if ($signed(r_data_rd.score) >= r_beta) begin
                        w_cut     = 1'b1;
                        w_cut_val = r_beta;
                    end
                end
                default: begin
                    w_cut = 1'b0;
                end
            endcase
        end
    end

    // store replaces empty, stale or shallower entries
    assign w_replace = !r_meta_rd.valid || (r_meta_rd.age != r_age)
                       || (r_meta_rd.depth < r_depth);

    assign w_meta_wdata = (r_state == ST_READ)
                          ? '{valid: 1'b1, depth: r_depth, age: r_age, flags: r_flags}
                          : '0;
    assign w_data_wdata = '{key: r_key, score: r_score, move: r_move,
                            move_valid: r_move_valid};

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_age        = r_age;
        n_mod_cnt    = r_mod_cnt;
        n_rem        = r_rem;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && i_out_stall;
        n_cutoff     = r_cutoff;
        n_score_out  = r_score_out;
        n_move_found = r_move_found;
        n_move_out   = r_move_out;
        n_key_hit    = r_key_hit;
        w_rd_en      = 1'b0;
        w_rd_addr    = i_key[IDX_W-1:0];
        w_meta_we    = 1'b0;
        w_meta_waddr = r_cnt;
        w_data_we    = 1'b0;

        if (i_cfg_wr_en) begin
            n_age = i_cfg_wr_data;
        end

        case (r_state)
            ST_INIT, ST_CLEAR: begin
                // one entry a cycle back to empty
                w_meta_we = 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_cnt   = '0;
                    n_state = (r_state == ST_CLEAR) ? ST_READ : ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_mode)
                        MODE_PROBE, MODE_STORE: begin
                            if (IS_POW2) begin
                                w_rd_en = 1'b1;
                                n_idx   = i_key[IDX_W-1:0];
                                n_state = ST_READ;
                            end else begin
                                n_rem     = '0;
                                n_mod_cnt = '0;
                                n_state   = ST_MOD;
                            end
                        end
                        MODE_CLEAR: begin
                            n_age   = '0;
                            n_cnt   = '0;
                            n_state = ST_CLEAR;
                        end
                        default: begin
                            // unused code: zero result, table untouched
                            n_state = ST_READ;
                        end
                    endcase
                end
            end
            ST_MOD: begin
                n_rem     = w_rem_step;
                n_mod_cnt = r_mod_cnt + 1'b1;
                if (r_mod_cnt == LAST_STEP) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_rem_step;
                    n_idx     = w_rem_step;
                    n_state   = ST_READ;
                end
            end
            ST_READ: begin
                // wait here until the result register can take the word
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_key_hit    = w_hit;
                    n_cutoff     = w_hit && w_cut;
                    n_score_out  = (w_hit && w_cut) ? w_cut_val : '0;
                    n_move_found = w_hit && !w_cut && r_data_rd.move_valid;
                    n_move_out   = (w_hit && !w_cut && r_data_rd.move_valid)
                                   ? r_data_rd.move : '0;
                    if ((r_mode == MODE_STORE) && w_replace) begin
                        w_meta_we    = 1'b1;
                        w_meta_waddr = r_idx;
                        w_data_we    = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cnt       <= '0;
            r_age       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_age       <= n_age;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mod_cnt    <= n_mod_cnt;
        r_rem        <= n_rem;
        r_idx        <= n_idx;
        r_cutoff     <= n_cutoff;
        r_score_out  <= n_score_out;
        r_move_found <= n_move_found;
        r_move_out   <= n_move_out;
        r_key_hit    <= n_key_hit;
        if (w_in_acc) begin
            r_mode       <= i_mode;
            r_key        <= i_key;
            r_depth      <= i_depth;
            r_alpha      <= i_alpha;
            r_beta       <= i_beta;
            r_score      <= i_score_in;
            r_flags      <= i_bound_flags;
            r_move       <= i_move_in;
            r_move_valid <= i_move_in_valid;
        end
    end

    // meta memory: sweep or store write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_meta_we) begin
            meta_mem[w_meta_waddr] <= w_meta_wdata;
        end
        if (w_rd_en) begin
            r_meta_rd <= meta_mem[w_rd_addr];
        end
    end

    // entry data memory: key, score and move
    always_ff @(posedge i_clk) begin
        if (w_data_we) begin
            data_mem[r_idx] <= w_data_wdata;
        end
        if (w_rd_en) begin
            r_data_rd <= data_mem[w_rd_addr];
        end
    end

    `SHT_ASSERT_NOW(a_result_from_read, $rose(r_out_valid), $past(r_state) == ST_READ,
        "result word loaded outside the read state")
    `SHT_ASSERT_NEXT(a_clear_age, w_in_acc && (i_mode == MODE_CLEAR), r_age == '0,
        "search age not zero after clear")
    `SHT_ASSERT_NEXT(a_read_holds, (r_state == ST_READ) && r_out_valid && i_out_stall,
        r_state == ST_READ, "read state left while result register is full")
    `SHT_ASSERT_NOW(a_mod_not_clear, r_state == ST_MOD, r_mode != MODE_CLEAR,
        "clear request sent through key reduction")

endmodule

FILE: tb/tb_search_hash_table_probe_store_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_search_hash_table_probe_store_core
// self-checking bench for the direct-mapped transposition table: probe, store
// and clear words go in over a valid/stall channel, every accepted word is run
// through a mirror of the table, and each result word is checked field by field
// ----------------------------------------------------------------------------
module tb_search_hash_table_probe_store_core;
    import sht_pkg::*;

    localparam int TBL          = TABLE_DEPTH_DEF;
    localparam int N_PHASES     = 8;
    localparam int PHASE_WORDS  = 166;
    localparam int KEY_POOL_MAX = 48;
    localparam int MAX_PRINTS   = 30;

    // mode 3 is unused by the block: nothing changes and the result is all zero
    localparam logic [MODE_W-1:0]  MODE_UNUSED = 2'd3;
    localparam logic [FLAGS_W-1:0] FLAGS_NONE  = 2'd0;

    // one request word as presented on the input channel
    typedef struct {
        logic [MODE_W-1:0]         mode;
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
        logic signed [SCORE_W-1:0] score;
        logic [FLAGS_W-1:0]        flags;
        logic [MOVE_W-1:0]         move;
        logic                      move_ok;
        bit                        drain_first;   // hold back until all results are in
    } probe_req_t;

    // one result word
    typedef struct {
        logic                      cutoff;
        logic signed [SCORE_W-1:0] score;
        logic                      move_found;
        logic [MOVE_W-1:0]         move;
        logic                      key_hit;
    } lookup_res_t;

    // mirror of one table entry
    typedef struct {
        bit                        valid;
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic [AGE_W-1:0]          age;
        logic [FLAGS_W-1:0]        flags;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         move;
        bit                        move_ok;
    } tt_slot_t;

    // ------------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------------
    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_cfg_wr_en     = 1'b0;
    logic [AGE_W-1:0]          i_cfg_wr_data   = '0;
    logic                      i_in_valid      = 1'b0;
    logic                      o_in_stall;
    logic [MODE_W-1:0]         i_mode          = MODE_PROBE;
    logic [KEY_W-1:0]          i_key           = '0;
    logic [DEPTH_W-1:0]        i_depth         = '0;
    logic signed [SCORE_W-1:0] i_alpha         = '0;
    logic signed [SCORE_W-1:0] i_beta          = '0;
    logic signed [SCORE_W-1:0] i_score_in      = '0;
    logic [FLAGS_W-1:0]        i_bound_flags   = FLAGS_NONE;
    logic [MOVE_W-1:0]         i_move_in       = '0;
    logic                      i_move_in_valid = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_stall     = 1'b0;
    logic                      o_cutoff;
    logic signed [SCORE_W-1:0] o_score_out;
    logic                      o_move_found;
    logic [MOVE_W-1:0]         o_move_out;
    logic                      o_key_hit;

    search_hash_table_probe_store_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_key           (i_key),
        .i_depth         (i_depth),
        .i_alpha         (i_alpha),
        .i_beta          (i_beta),
        .i_score_in      (i_score_in),
        .i_bound_flags   (i_bound_flags),
        .i_move_in       (i_move_in),
        .i_move_in_valid (i_move_in_valid),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cutoff        (o_cutoff),
        .o_score_out     (o_score_out),
        .o_move_found    (o_move_found),
        .o_move_out      (o_move_out),
        .o_key_hit       (o_key_hit)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    tt_slot_t           tt_mirror [TBL];
    logic [AGE_W-1:0]   age_mirror = '0;

    probe_req_t         pending_words [$];    // filled by the scenario, drained by the driver
    lookup_res_t        expected_lookups [$]; // predicted result words, oldest first
    logic [KEY_W-1:0]   known_keys [$];       // keys of recent store words, at most KEY_POOL_MAX of them

    probe_req_t         cur_word;
    bit                 word_on_bus    = 1'b0;
    bit                 in_fire_s      = 1'b0; // input handshake seen at the last rising edge
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 mismatch_count = 0;
    int                 results_seen   = 0;

    // clock: 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // ------------------------------------------------------------------------
    // table mirror: works out the result word of one request and applies its
    // side effects (store replacement, clear)
    // ------------------------------------------------------------------------
    function automatic lookup_res_t apply_request(input probe_req_t r);
        lookup_res_t res;
        tt_slot_t    slot;
        int          idx;
        res.cutoff     = 1'b0;
        res.score      = '0;
        res.move_found = 1'b0;
        res.move       = '0;
        res.key_hit    = 1'b0;
        idx  = int'(r.key % TBL);
        slot = tt_mirror[idx];
        case (r.mode)
            MODE_PROBE: begin
                if (slot.valid && slot.key == r.key) begin
                    res.key_hit = 1'b1;
                    // cutoff only for requests deeper than the minimum and no
                    // deeper than what was stored
                    if (r.depth > CUT_MIN_DEPTH && r.depth <= slot.depth) begin
                        case (slot.flags)
                            FLAGS_EXACT: begin
                                res.cutoff = 1'b1;
                                res.score  = slot.score;
                            end
                            FLAGS_UPPER: begin
                                if (slot.score <= r.alpha) begin
                                    res.cutoff = 1'b1;
                                    res.score  = r.alpha;
                                end
                            end
                            FLAGS_LOWER: begin
                                if (slot.score >= r.beta) begin
                                    res.cutoff = 1'b1;
                                    res.score  = r.beta;
                                end
                            end
                            default: ;
                        endcase
                    end
                    // no cutoff: hand back the best move if there is one
                    if (!res.cutoff && slot.move_ok) begin
                        res.move_found = 1'b1;
                        res.move       = slot.move;
                    end
                end
            end
            MODE_STORE: begin
                // empty, stale generation or shallower entry gets replaced
                if (!slot.valid || slot.age != age_mirror || slot.depth < r.depth) begin
                    slot.valid   = 1'b1;
                    slot.key     = r.key;
                    slot.depth   = r.depth;
                    slot.age     = age_mirror;
                    slot.flags   = r.flags;
                    slot.score   = r.score;
                    slot.move    = r.move;
                    slot.move_ok = r.move_ok;
                    tt_mirror[idx] = slot;
                end
            end
            MODE_CLEAR: begin
                // whole table emptied and the search generation back to zero
                foreach (tt_mirror[i]) begin
                    tt_mirror[i].valid = 1'b0;
                end
                age_mirror = '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic probe_req_t make_req(input logic [MODE_W-1:0] m,
                                            input logic [KEY_W-1:0] k, input int d,
                                            input int a, input int b, input int s,
                                            input logic [FLAGS_W-1:0] f,
                                            input logic [MOVE_W-1:0] mv, input bit mok);
        probe_req_t r;
        r.mode        = m;
        r.key         = k;
        r.depth       = DEPTH_W'(d);
        r.alpha       = SCORE_W'(a);
        r.beta        = SCORE_W'(b);
        r.score       = SCORE_W'(s);
        r.flags       = f;
        r.move        = mv;
        r.move_ok     = mok;
        r.drain_first = 1'b0;
        return r;
    endfunction

    // a different key that lands on the same entry
    function automatic logic [KEY_W-1:0] alias_key(input logic [KEY_W-1:0] base);
        logic [KEY_W-1:0] step;
        step = KEY_W'(TBL) * {$urandom, $urandom};
        if (step == '0) begin
            step = KEY_W'(TBL);
        end
        return base + step;
    endfunction

    // half the scores near zero so that window compares go both ways
    function automatic logic signed [SCORE_W-1:0] pick_score();
        if ($urandom_range(0, 1) == 0) begin
            return SCORE_W'($urandom);
        end
        return SCORE_W'(int'($urandom_range(0, 127)) - 64);
    endfunction

    function automatic probe_req_t random_request();
        probe_req_t       r;
        logic [KEY_W-1:0] base;
        int               pick;
        int               sub;
        r.key         = {$urandom, $urandom};
        r.depth       = ($urandom_range(0, 4) == 0) ? DEPTH_W'($urandom)
                                                    : DEPTH_W'($urandom_range(0, 15));
        r.alpha       = pick_score();
        r.beta        = pick_score();
        r.score       = pick_score();
        r.flags       = FLAGS_W'($urandom);
        r.move        = $urandom;
        r.move_ok     = $urandom_range(0, 1);
        r.drain_first = ($urandom_range(0, 199) == 0);
        // probes, clears and unused modes take their keys from earlier store words or their aliases
        base = known_keys[$urandom_range(0, known_keys.size() - 1)];
        pick = $urandom_range(0, 999);
        sub  = $urandom_range(0, 9);
        if (pick < 5) begin
            r.mode = MODE_CLEAR;
            r.key  = base;
        end else if (pick < 55) begin
            r.mode = MODE_UNUSED;
            r.key  = base;
        end else if (pick < 480) begin
            r.mode = MODE_STORE;
            if (sub < 4) begin
                r.key = base;                 // rewrite: age and depth decide
            end else if (sub < 7) begin
                r.key = alias_key(base);      // collision with another key
            end
        end else begin
            r.mode = MODE_PROBE;
            r.key  = (sub < 8) ? base : alias_key(base);
        end
        return r;
    endfunction

    task automatic queue_word(input probe_req_t r);
        pending_words.push_back(r);
        if (r.mode == MODE_STORE) begin
            known_keys.push_back(r.key);
            if (known_keys.size() > KEY_POOL_MAX) begin
                void'(known_keys.pop_front());
            end
        end
    endtask

    task automatic wait_until_drained();
        while (pending_words.size() != 0 || word_on_bus || expected_lookups.size() != 0) begin
            @(negedge i_clk);
        end
        // give the result path a little slack
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_age(input logic [AGE_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        age_mirror = v;
    endtask

    // ------------------------------------------------------------------------
    // request driver: changes on the falling edge, holds a word until taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : request_driver
        lookup_res_t res;
        if (i_rst_n) begin
            if (in_fire_s) begin
                // word taken at the last rising edge: predict in acceptance order
                res = apply_request(cur_word);
                expected_lookups.push_back(res);
                word_on_bus = 1'b0;
            end
            if (!word_on_bus && pending_words.size() != 0
                    && !(pending_words[0].drain_first && expected_lookups.size() != 0)
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_word = pending_words.pop_front();
                word_on_bus = 1'b1;
                i_mode          <= cur_word.mode;
                i_key           <= cur_word.key;
                i_depth         <= cur_word.depth;
                i_alpha         <= cur_word.alpha;
                i_beta          <= cur_word.beta;
                i_score_in      <= cur_word.score;
                i_bound_flags   <= cur_word.flags;
                i_move_in       <= cur_word.move;
                i_move_in_valid <= cur_word.move_ok;
            end
            i_in_valid <= word_on_bus;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin : result_stall
        i_out_stall <= i_rst_n && ($urandom_range(0, 99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // monitor: samples both handshakes on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        lookup_res_t want;
        in_fire_s = i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_lookups.size() == 0) begin
                report_mismatch($sformatf("result word %0d with nothing expected",
                                          results_seen));
            end else begin
                want = expected_lookups.pop_front();
                if (o_key_hit !== want.key_hit) begin
                    report_mismatch($sformatf("word %0d key_hit got %b want %b",
                                              results_seen, o_key_hit, want.key_hit));
                end
                if (o_cutoff !== want.cutoff) begin
                    report_mismatch($sformatf("word %0d cutoff got %b want %b",
                                              results_seen, o_cutoff, want.cutoff));
                end
                if (o_score_out !== want.score) begin
                    report_mismatch($sformatf("word %0d score_out got %0d want %0d",
                                              results_seen, o_score_out, want.score));
                end
                if (o_move_found !== want.move_found) begin
                    report_mismatch($sformatf("word %0d move_found got %b want %b",
                                              results_seen, o_move_found, want.move_found));
                end
                if (o_move_out !== want.move) begin
                    report_mismatch($sformatf("word %0d move_out got %h want %h",
                                              results_seen, o_move_out, want.move));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // scenario: reset, then phases of differing search age and idling
    // ------------------------------------------------------------------------
    initial begin : scenario
        probe_req_t       r;
        logic [AGE_W-1:0] age;
        logic [KEY_W-1:0] k_lo;
        logic [KEY_W-1:0] k_hi;
        logic [KEY_W-1:0] k_mid;
        logic [KEY_W-1:0] k_lb;
        logic [KEY_W-1:0] k_none;
        k_lo   = '0;
        k_hi   = '1;
        k_mid  = 64'h0123_4567_89AB_C155;
        k_lb   = 64'h8000_0000_0000_0200;
        k_none = 64'h5A5A_0000_0000_0077;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // table is swept after reset with the input stalled
        do @(posedge i_clk); while (o_in_stall);

        for (int p = 0; p < N_PHASES; p++) begin
            wait_until_drained();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            case (p)
                0: age = '0;
                1: age = '1;
                3: age = 16'h8000;
                5: age = 16'd1;
                default: age = AGE_W'($urandom);
            endcase
            write_age(age);

            if (p == 0) begin
                // exact entry at index 0, all-ones move
                queue_word(make_req(MODE_STORE, k_lo, 10, 0, 0, 32767, FLAGS_EXACT, '1, 1));
                queue_word(make_req(MODE_PROBE, k_lo, 3, 0, 0, 0, FLAGS_NONE, '0, 0));
                // too shallow and too deep for a cutoff: move comes back instead
                queue_word(make_req(MODE_PROBE, k_lo, 2, 0, 0, 0, FLAGS_NONE, '0, 0));
                queue_word(make_req(MODE_PROBE, k_lo, 11, 0, 0, 0, FLAGS_NONE, '0, 0));
                // same index, other key: miss
                queue_word(make_req(MODE_PROBE, k_lo ^ 64'h8000_0000_0000_0000, 5, 0, 0, 0,
                                    FLAGS_NONE, '0, 0));
                // upper bound at the last index, score equal to alpha
                queue_word(make_req(MODE_STORE, k_hi, 127, 0, 0, -32768, FLAGS_UPPER, '0, 0));
                queue_word(make_req(MODE_PROBE, k_hi, 127, -32768, 32767, 0, FLAGS_NONE,
                                    '0, 0));
                queue_word(make_req(MODE_STORE, k_mid, 4, 0, 0, 100, FLAGS_UPPER,
                                    32'h0000_1234, 1));
                queue_word(make_req(MODE_PROBE, k_mid, 4, 99, 0, 0, FLAGS_NONE, '0, 0));
                queue_word(make_req(MODE_PROBE, k_mid, 4, 100, 0, 0, FLAGS_NONE, '0, 0));
                // lower bound: beta equal cuts, beta above does not
                queue_word(make_req(MODE_STORE, k_lb, 6, 0, 0, 50, FLAGS_LOWER, '0, 0));
                queue_word(make_req(MODE_PROBE, k_lb, 6, 0, 50, 0, FLAGS_NONE, '0, 0));
                queue_word(make_req(MODE_PROBE, k_lb, 6, 0, 51, 0, FLAGS_NONE, '0, 0));
                // no bound flags never cut off
                queue_word(make_req(MODE_STORE, k_none, 127, 0, 0, 0, FLAGS_NONE,
                                    32'hAAAA_5555, 1));
                queue_word(make_req(MODE_PROBE, k_none, 127, 32767, -32768, 0, FLAGS_NONE,
                                    '0, 0));
                // same age: shallower and equal depth keep the old entry, deeper replaces
                queue_word(make_req(MODE_STORE, k_lo, 5, 0, 0, -1, FLAGS_EXACT, '0, 0));
                queue_word(make_req(MODE_STORE, k_lo, 10, 0, 0, -1, FLAGS_EXACT, '0, 0));
                queue_word(make_req(MODE_PROBE, k_lo, 10, 0, 0, 0, FLAGS_NONE, '0, 0));
                queue_word(make_req(MODE_STORE, k_lo, 11, 0, 0, -1, FLAGS_EXACT, '0, 0));
                queue_word(make_req(MODE_PROBE, k_lo, 11, 0, 0, 0, FLAGS_NONE, '0, 0));
                queue_word(make_req(MODE_UNUSED, k_hi, 127, -1, -1, -1, FLAGS_EXACT, '1, 1));
                // clear after a full drain, then a probe that must now miss
                r = make_req(MODE_CLEAR, k_lo, 0, 0, 0, 0, FLAGS_NONE, '0, 0);
                r.drain_first = 1'b1;
                queue_word(r);
                queue_word(make_req(MODE_PROBE, k_hi, 127, -32768, 32767, 0, FLAGS_NONE,
                                    '0, 0));
                // store into an emptied entry always lands
                queue_word(make_req(MODE_STORE, k_hi, 0, 0, 0, 7, FLAGS_EXACT, '0, 1));
            end

            repeat (PHASE_WORDS) queue_word(random_request());
        end

        wait_until_drained();
        repeat (16) @(posedge i_clk);
        if (expected_lookups.size() != 0) begin
            report_mismatch($sformatf("%0d result words never arrived",
                                      expected_lookups.size()));
        end
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run, clear sweeps included
    initial begin : watchdog
        #1_600_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/sht_pkg.sv
src/search_hash_table_probe_store_core.sv
tb/tb_search_hash_table_probe_store_core.sv
